// ===== rtl/tbp_pkg.sv =====
package tbp_pkg;

   localparam int GLOBAL_HIST_BITS = 9;
   localparam int LOCAL_HIST_BITS  = 10;
   localparam int PC_INDEX_BITS    = 10;

   localparam int CLR_BITS_A = (GLOBAL_HIST_BITS > LOCAL_HIST_BITS) ?
                               GLOBAL_HIST_BITS : LOCAL_HIST_BITS;
   localparam int CLR_BITS   = (CLR_BITS_A > PC_INDEX_BITS) ? CLR_BITS_A : PC_INDEX_BITS;

   localparam logic [1:0] CTR_MAX      = 2'd3;
   localparam logic [1:0] CTR_MIN      = 2'd0;
   localparam logic [1:0] CTR_INIT     = 2'd1;
   localparam logic [1:0] CHOOSER_INIT = 2'd3;

   typedef logic [GLOBAL_HIST_BITS-1:0] ghist_type;
   typedef logic [LOCAL_HIST_BITS-1:0]  lhist_type;
   typedef logic [PC_INDEX_BITS-1:0]    pc_idx_type;
   typedef logic [CLR_BITS-1:0]         clr_cnt_type;

   typedef struct packed {
      logic [31:0] branch_pc;
      logic        taken;
   } req_type;

   typedef struct packed {
      logic prediction;
      logic global_guess;
      logic local_guess;
   } rsp_type;

   // global table entry: chooser in the upper pair, global counter in the lower
   typedef struct packed {
      logic [1:0] chooser;
      logic [1:0] counter;
   } glb_entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_HIST,
      ST_READ_CTR
   } state_type;

   function automatic logic [1:0] bump(input logic [1:0] ctr, input logic up);
      logic [1:0] res;
      res = ctr;
      if (up) begin
         if (ctr != CTR_MAX) res = ctr + 2'd1;
      end else begin
         if (ctr != CTR_MIN) res = ctr - 2'd1;
      end
      return res;
   endfunction

endpackage

// ===== rtl/tbp_ram.sv =====
module tbp_ram #(
   parameter int DATA_W = 2,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tournament_branch_predictor_top.sv =====
// Each item takes two dependent RAM reads (history table, then local counter); the result
// registers with the update.
// A new item is accepted only after the previous one is updated, following its chained
// history-table and local-counter reads; a waiting result does not block the next accept.
// Reset: synchronous; a clearing pass over 2^max(index widths) = 1024 addresses loads all
// tables with their init values, and no item is accepted during it.
module tournament_branch_predictor_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tbp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tbp_pkg::rsp_type rsp_data
);

   tbp_pkg::state_type   state_ff, state_in;
   tbp_pkg::clr_cnt_type clr_cnt_ff, clr_cnt_in;
   tbp_pkg::ghist_type   path_ff, path_in;
   tbp_pkg::pc_idx_type  pc_idx_ff;
   logic                 taken_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   tbp_pkg::rsp_type     rsp_data_ff;

   logic                   req_fire;
   logic                   clr_done;
   logic                   commit;

   logic                   glb_wr_en, glb_rd_en;
   tbp_pkg::ghist_type     glb_wr_addr;
   tbp_pkg::glb_entry_type glb_wr_data, glb_rd_data;

   logic                   lh_wr_en, lh_rd_en;
   tbp_pkg::pc_idx_type    lh_wr_addr;
   tbp_pkg::lhist_type     lh_wr_data, lh_rd_data;

   logic                   lc_wr_en, lc_rd_en;
   tbp_pkg::lhist_type     lc_wr_addr;
   logic [1:0]             lc_wr_data, lc_rd_data;

   logic                   g_guess, l_guess, pred, g_ok, l_ok;
   logic [1:0]             cho_next;
   tbp_pkg::rsp_type       rsp_next;

   assign req_ready = (state_ff == tbp_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign clr_done  = (clr_cnt_ff == '1);
   // result slot free, or emptied this cycle
   assign commit    = (state_ff == tbp_pkg::ST_READ_CTR) && (!rsp_valid_ff || rsp_ready);

   // prediction and training values
   assign g_guess = glb_rd_data.counter[1];
   assign l_guess = lc_rd_data[1];
   assign pred    = glb_rd_data.chooser[1] ? g_guess : l_guess;
   assign g_ok    = (g_guess == taken_ff);
   assign l_ok    = (l_guess == taken_ff);

   always_comb begin
      cho_next = glb_rd_data.chooser;
      if (g_ok && !l_ok) begin
         cho_next = tbp_pkg::bump(glb_rd_data.chooser, 1'b1);
      end else if (l_ok && !g_ok) begin
         cho_next = tbp_pkg::bump(glb_rd_data.chooser, 1'b0);
      end
   end

   assign rsp_next.prediction   = pred;
   assign rsp_next.global_guess = g_guess;
   assign rsp_next.local_guess  = l_guess;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tbp_pkg::ST_CLEAR: begin
            if (clr_done) state_in = tbp_pkg::ST_IDLE;
         end
         tbp_pkg::ST_IDLE: begin
            if (req_fire) state_in = tbp_pkg::ST_READ_HIST;
         end
         tbp_pkg::ST_READ_HIST: begin
            state_in = tbp_pkg::ST_READ_CTR;
         end
         tbp_pkg::ST_READ_CTR: begin
            if (commit) state_in = tbp_pkg::ST_IDLE;
         end
         default: state_in = tbp_pkg::ST_CLEAR;
      endcase
   end

   // outputs: table accesses and register updates
   always_comb begin
      glb_rd_en   = 1'b0;
      lh_rd_en    = 1'b0;
      lc_rd_en    = 1'b0;
      glb_wr_en   = 1'b0;
      lh_wr_en    = 1'b0;
      lc_wr_en    = 1'b0;
      glb_wr_addr = path_ff;
      glb_wr_data = '{chooser: cho_next,
                      counter: tbp_pkg::bump(glb_rd_data.counter, taken_ff)};
      lh_wr_addr  = pc_idx_ff;
      lh_wr_data  = tbp_pkg::lhist_type'({lh_rd_data, taken_ff});
      lc_wr_addr  = lh_rd_data;
      lc_wr_data  = tbp_pkg::bump(lc_rd_data, taken_ff);
      clr_cnt_in  = clr_cnt_ff;
      path_in     = path_ff;
      unique case (state_ff)
         tbp_pkg::ST_CLEAR: begin
            glb_wr_en   = 1'b1;
            lh_wr_en    = 1'b1;
            lc_wr_en    = 1'b1;
            glb_wr_addr = clr_cnt_ff[tbp_pkg::GLOBAL_HIST_BITS-1:0];
            glb_wr_data = '{chooser: tbp_pkg::CHOOSER_INIT, counter: tbp_pkg::CTR_INIT};
            lh_wr_addr  = clr_cnt_ff[tbp_pkg::PC_INDEX_BITS-1:0];
            lh_wr_data  = '0;
            lc_wr_addr  = clr_cnt_ff[tbp_pkg::LOCAL_HIST_BITS-1:0];
            lc_wr_data  = tbp_pkg::CTR_INIT;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
         end
         tbp_pkg::ST_IDLE: begin
            glb_rd_en = req_fire;
            lh_rd_en  = req_fire;
         end
         tbp_pkg::ST_READ_HIST: begin
            lc_rd_en = 1'b1;
         end
         tbp_pkg::ST_READ_CTR: begin
            glb_wr_en = commit;
            lh_wr_en  = commit;
            lc_wr_en  = commit;
            if (commit) path_in = tbp_pkg::ghist_type'({path_ff, taken_ff});
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbp_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         path_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         path_ff      <= path_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pc_idx_ff <= req_data.branch_pc[tbp_pkg::PC_INDEX_BITS-1:0];
         taken_ff  <= req_data.taken;
      end
      if (commit) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // global counters and chooser share an index, so they share one RAM
   tbp_ram #(
      .DATA_W ($bits(tbp_pkg::glb_entry_type)),
      .ADDR_W (tbp_pkg::GLOBAL_HIST_BITS)
   ) u_glb_ram (
      .clock   (clock),
      .wr_en   (glb_wr_en),
      .wr_addr (glb_wr_addr),
      .wr_data (glb_wr_data),
      .rd_en   (glb_rd_en),
      .rd_addr (path_ff),
      .rd_data (glb_rd_data)
   );

   tbp_ram #(
      .DATA_W (tbp_pkg::LOCAL_HIST_BITS),
      .ADDR_W (tbp_pkg::PC_INDEX_BITS)
   ) u_lhist_ram (
      .clock   (clock),
      .wr_en   (lh_wr_en),
      .wr_addr (lh_wr_addr),
      .wr_data (lh_wr_data),
      .rd_en   (lh_rd_en),
      .rd_addr (req_data.branch_pc[tbp_pkg::PC_INDEX_BITS-1:0]),
      .rd_data (lh_rd_data)
   );

   tbp_ram #(
      .DATA_W (2),
      .ADDR_W (tbp_pkg::LOCAL_HIST_BITS)
   ) u_lctr_ram (
      .clock   (clock),
      .wr_en   (lc_wr_en),
      .wr_addr (lc_wr_addr),
      .wr_data (lc_wr_data),
      .rd_en   (lc_rd_en),
      .rd_addr (lh_rd_data),
      .rd_data (lc_rd_data)
   );

`ifndef ASSERT_OFF
   // a stalled result must hold the update back
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tbp_pkg::ST_READ_CTR && rsp_valid && !rsp_ready)
      |=> (state_ff == tbp_pkg::ST_READ_CTR && $stable(rsp_data)))
      else $error("result overwritten while stalled");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tbp_pkg::ST_IDLE) |-> !(glb_wr_en || lh_wr_en || lc_wr_en))
      else $error("table write while idle");

   a_accept_to_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> ##1 (state_ff == tbp_pkg::ST_READ_CTR))
      else $error("item did not reach update step");

   a_clear_start: assert property (@(posedge clock)
      $fell(reset) |-> (state_ff == tbp_pkg::ST_CLEAR && clr_cnt_ff == '0 && !rsp_valid))
      else $error("clearing pass did not start after reset");
`endif

endmodule
